// File: rtl/cet_pkg.sv
// ----------------------------------------------------------------------------
// cet_pkg
// Shared types, codes and siphash round helpers for the edge trimmer.
// ----------------------------------------------------------------------------
package cet_pkg;

    localparam int EDGE_REQ_W  = 12;
    localparam int ENDPOINT_W  = 12;
    localparam int CMD_W       = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int EPOCH_BITS  = 4;
    localparam int SIP_ROUNDS  = 6;
    localparam int SIP_PRE_RND = 2;

    localparam logic [CMD_W-1:0] CMD_MARK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TRIM   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_REVIVE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_D = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE  = 3'd4;

    localparam logic [63:0] SIP_V2_TWEAK = 64'hff;

    typedef struct packed {
        logic [CMD_W-1:0]      cmd;
        logic [EDGE_REQ_W-1:0] edge_req;
    } t_in_item;

    typedef struct packed {
        logic [ENDPOINT_W-1:0] endpoint;
        logic                  was_live;
        logic                  seen_twice;
        logic                  live_after;
    } t_out_item;

    typedef struct packed {
        logic [63:0] v0;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] v3;
    } t_sip_state;

    // per-stage control that rides along the pipeline
    typedef struct packed {
        logic             vld;
        logic [CMD_W-1:0] cmd;
    } t_ctl;

    function automatic logic [63:0] rotl64(logic [63:0] x, int unsigned n);
        return (x << n) | (x >> (64 - n));
    endfunction

    // first half of a sipround: one level of adds
    function automatic t_sip_state sip_half_a(t_sip_state s);
        t_sip_state o;
        o.v0 = s.v0 + s.v1;
        o.v2 = s.v2 + s.v3;
        o.v1 = rotl64(s.v1, 13) ^ o.v0;
        o.v3 = rotl64(s.v3, 16) ^ o.v2;
        o.v0 = rotl64(o.v0, 32);
        return o;
    endfunction

    // second half of a sipround
    function automatic t_sip_state sip_half_b(t_sip_state s);
        t_sip_state o;
        o.v2 = s.v2 + s.v1;
        o.v0 = s.v0 + s.v3;
        o.v1 = rotl64(s.v1, 17) ^ o.v2;
        o.v3 = rotl64(s.v3, 21) ^ o.v0;
        o.v2 = rotl64(o.v2, 32);
        return o;
    endfunction

endpackage

// File: rtl/cuckoo_edge_trimmer.sv
// ----------------------------------------------------------------------------
// cuckoo_edge_trimmer
// Lean edge trimming for a cuckoo-cycle graph with a keyed siphash endpoint.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------
//   in      | input     | i_in_valid / o_in_ready | i_in_data  (t_in_item)
//   out     | output    | o_out_valid/ i_out_ready| o_out_data (t_out_item)
//   cfg     | input     | i_cfg_we                | i_cfg_addr, i_cfg_wdata
//
// One transaction per cycle sustained while the result register is not stalled
// and no sweep runs; a result passes the input register, twelve half-round
// stages of the siphash pipeline, the map read register and the result register.
// After reset both maps are swept over all 2^EDGE_BITS entries with o_in_ready low;
// a map is swept again on every sixteenth clear (degree map) or revive (live map).
// A stalled result register holds the whole pipeline.
// ----------------------------------------------------------------------------
module cuckoo_edge_trimmer #(
    parameter int EDGE_BITS = 12
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  cet_pkg::t_in_item                    i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output cet_pkg::t_out_item                   o_out_data,
    input  logic                                 i_cfg_we,
    input  logic [cet_pkg::CFG_IDX_W-1:0]        i_cfg_addr,
    input  logic [cet_pkg::CFG_DATA_W-1:0]       i_cfg_wdata
);
    import cet_pkg::*;

    t_sip_state            r_key;
    logic                  r_side;
    t_ctl                  r_in_ctl;
    logic [EDGE_BITS:0]    r_in_nonce;
    logic                  r_out_vld;
    t_out_item             r_out_data;

    logic                  en;
    logic                  busy;
    logic [EDGE_BITS+EDGE_REQ_W-1:0] edge_ext;
    logic [EDGE_BITS-1:0]  edge_idx;
    t_ctl                  n_in_ctl;
    t_ctl                  pipe_ctl;
    logic [EDGE_BITS:0]    pipe_nonce;
    t_sip_state            pipe_v;
    logic                  res_vld;
    t_out_item             res;

    assign en         = (!r_out_vld || i_out_ready) && !busy;
    assign o_in_ready = en;

    assign edge_ext = {{EDGE_BITS{1'b0}}, i_in_data.edge_req};
    assign edge_idx = edge_ext[EDGE_BITS-1:0];

    assign n_in_ctl.vld = i_in_valid;
    assign n_in_ctl.cmd = i_in_data.cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key  <= '0;
            r_side <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_KEY_A: r_key.v0 <= i_cfg_wdata;
                CFG_KEY_B: r_key.v1 <= i_cfg_wdata;
                CFG_KEY_C: r_key.v2 <= i_cfg_wdata;
                CFG_KEY_D: r_key.v3 <= i_cfg_wdata;
                CFG_SIDE:  r_side   <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ctl  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (en) begin
                r_in_ctl  <= n_in_ctl;
                r_out_vld <= res_vld;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // nonce is 2*edge + side
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_nonce <= {edge_idx, r_side};
            r_out_data <= res;
        end
    end

    cet_sip_pipe #(
        .EDGE_BITS (EDGE_BITS)
    ) u_sip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_key   (r_key),
        .i_ctl   (r_in_ctl),
        .i_nonce (r_in_nonce),
        .o_ctl   (pipe_ctl),
        .o_nonce (pipe_nonce),
        .o_v     (pipe_v)
    );

    cet_maps #(
        .EDGE_BITS (EDGE_BITS)
    ) u_maps (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (pipe_ctl),
        .i_nonce (pipe_nonce),
        .i_v     (pipe_v),
        .o_vld   (res_vld),
        .o_res   (res),
        .o_busy  (busy)
    );

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

endmodule

// File: rtl/cet_sip_round.sv
// ----------------------------------------------------------------------------
// cet_sip_round
// One siphash round as two register stages, one half-round each.
// ----------------------------------------------------------------------------
module cet_sip_round #(
    parameter int EDGE_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  cet_pkg::t_ctl         i_ctl,
    input  logic [EDGE_BITS:0]    i_nonce,
    input  cet_pkg::t_sip_state   i_v,
    output cet_pkg::t_ctl         o_ctl,
    output logic [EDGE_BITS:0]    o_nonce,
    output cet_pkg::t_sip_state   o_v
);
    import cet_pkg::*;

    t_ctl               r_mid_ctl;
    logic [EDGE_BITS:0] r_mid_nonce;
    t_sip_state         r_mid_v;
    t_ctl               r_out_ctl;
    logic [EDGE_BITS:0] r_out_nonce;
    t_sip_state         r_out_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_ctl <= '0;
            r_out_ctl <= '0;
        end else if (i_en) begin
            r_mid_ctl <= i_ctl;
            r_out_ctl <= r_mid_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mid_nonce <= i_nonce;
            r_mid_v     <= sip_half_a(i_v);
            r_out_nonce <= r_mid_nonce;
            r_out_v     <= sip_half_b(r_mid_v);
        end
    end

    assign o_ctl   = r_out_ctl;
    assign o_nonce = r_out_nonce;
    assign o_v     = r_out_v;

endmodule

// File: rtl/cet_sip_pipe.sv
// ----------------------------------------------------------------------------
// cet_sip_pipe
// Keyed siphash pipeline: seeds the state, runs two rounds, folds in the
// nonce and the v2 tweak, then runs four more rounds.
// ----------------------------------------------------------------------------
module cet_sip_pipe #(
    parameter int EDGE_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  cet_pkg::t_sip_state   i_key,
    input  cet_pkg::t_ctl         i_ctl,
    input  logic [EDGE_BITS:0]    i_nonce,
    output cet_pkg::t_ctl         o_ctl,
    output logic [EDGE_BITS:0]    o_nonce,
    output cet_pkg::t_sip_state   o_v
);
    import cet_pkg::*;

    t_ctl               st_ctl   [SIP_ROUNDS+1];
    logic [EDGE_BITS:0] st_nonce [SIP_ROUNDS+1];
    t_sip_state         st_v     [SIP_ROUNDS+1];
    logic [63:0]        seed_nonce;

    assign seed_nonce = {{(63 - EDGE_BITS){1'b0}}, i_nonce};

    always_comb begin
        st_v[0]    = i_key;
        st_v[0].v3 = i_key.v3 ^ seed_nonce;
    end
    assign st_ctl[0]   = i_ctl;
    assign st_nonce[0] = i_nonce;

    for (genvar g = 0; g < SIP_ROUNDS; g++) begin : g_round
        logic [63:0] nonce_ext;
        t_sip_state  v_in;

        assign nonce_ext = {{(63 - EDGE_BITS){1'b0}}, st_nonce[g]};

        // nonce and tweak go in between the leading and trailing rounds
        always_comb begin
            v_in = st_v[g];
            if (g == SIP_PRE_RND) begin
                v_in.v0 = st_v[g].v0 ^ nonce_ext;
                v_in.v2 = st_v[g].v2 ^ SIP_V2_TWEAK;
            end
        end

        cet_sip_round #(
            .EDGE_BITS (EDGE_BITS)
        ) u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_ctl   (st_ctl[g]),
            .i_nonce (st_nonce[g]),
            .i_v     (v_in),
            .o_ctl   (st_ctl[g+1]),
            .o_nonce (st_nonce[g+1]),
            .o_v     (st_v[g+1])
        );
    end

    assign o_ctl   = st_ctl[SIP_ROUNDS];
    assign o_nonce = st_nonce[SIP_ROUNDS];
    assign o_v     = st_v[SIP_ROUNDS];

endmodule

// File: rtl/cet_maps.sv
// ----------------------------------------------------------------------------
// cet_maps
// Live map and degree map with epoch tags, one-deep write forwarding,
// and a clearing sweep after reset and on epoch wrap.
// ----------------------------------------------------------------------------
module cet_maps #(
    parameter int EDGE_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  cet_pkg::t_ctl         i_ctl,
    input  logic [EDGE_BITS:0]    i_nonce,
    input  cet_pkg::t_sip_state   i_v,
    output logic                  o_vld,
    output cet_pkg::t_out_item    o_res,
    output logic                  o_busy
);
    import cet_pkg::*;

    localparam int DEPTH = 1 << EDGE_BITS;
    localparam int LW    = EPOCH_BITS + 1;
    localparam int SW    = EPOCH_BITS + 2;
    localparam logic [EPOCH_BITS-1:0] EP_ZERO = '0;

    // word layout: {tag, live} and {tag, twice, once}
    logic [LW-1:0] live_mem [DEPTH];
    logic [SW-1:0] seen_mem [DEPTH];

    logic [63:0]           h_fold;
    logic [EDGE_BITS-1:0]  h_node;
    logic [EDGE_BITS-1:0]  h_edge;

    t_ctl                  r_ctl;
    logic [EDGE_BITS-1:0]  r_edge;
    logic [EDGE_BITS-1:0]  r_node;
    logic [LW-1:0]         r_live_q;
    logic [SW-1:0]         r_seen_q;
    logic                  r_kill_live;
    logic                  r_kill_seen;
    logic                  r_fwl_vld;
    logic [EDGE_BITS-1:0]  r_fwl_addr;
    logic                  r_fws_vld;
    logic [EDGE_BITS-1:0]  r_fws_addr;
    logic                  r_fws_twice;
    logic [EPOCH_BITS-1:0] r_ep_live;
    logic [EPOCH_BITS-1:0] r_ep_seen;
    logic                  r_swp_live;
    logic                  r_swp_seen;
    logic [EDGE_BITS-1:0]  r_swp_cnt;

    logic                  live_bit;
    logic                  once_b;
    logic                  twice_b;
    logic                  is_mark;
    logic                  is_trim;
    logic                  act;
    logic                  twice_new;
    logic                  live_we;
    logic                  seen_we;
    logic                  clr;
    logic                  rev;
    logic [EPOCH_BITS-1:0] n_ep_live;
    logic [EPOCH_BITS-1:0] n_ep_seen;
    logic [EDGE_BITS+ENDPOINT_W-1:0] node_ext;

    assign h_fold = i_v.v0 ^ i_v.v1 ^ i_v.v2 ^ i_v.v3;
    assign h_node = h_fold[EDGE_BITS-1:0];
    assign h_edge = i_nonce[EDGE_BITS:1];

    assign o_busy = r_swp_live | r_swp_seen;

    // resolve the stored words: forwarded write first, then stale tags
    always_comb begin
        if (r_fwl_vld && r_fwl_addr == r_edge) begin
            live_bit = 1'b0;
        end else if (r_kill_live || r_live_q[LW-1:1] != r_ep_live) begin
            live_bit = 1'b1;
        end else begin
            live_bit = r_live_q[0];
        end

        if (r_fws_vld && r_fws_addr == r_node) begin
            once_b  = 1'b1;
            twice_b = r_fws_twice;
        end else if (r_kill_seen || r_seen_q[SW-1:2] != r_ep_seen) begin
            once_b  = 1'b0;
            twice_b = 1'b0;
        end else begin
            once_b  = r_seen_q[0];
            twice_b = r_seen_q[1];
        end
    end

    assign is_mark   = (r_ctl.cmd == CMD_MARK);
    assign is_trim   = (r_ctl.cmd == CMD_TRIM);
    assign clr       = r_ctl.vld && (r_ctl.cmd == CMD_CLEAR);
    assign rev       = r_ctl.vld && (r_ctl.cmd == CMD_REVIVE);
    assign act       = r_ctl.vld && (is_mark || is_trim) && live_bit;
    assign twice_new = is_mark ? (twice_b | once_b) : twice_b;
    assign seen_we   = act && is_mark;
    assign live_we   = act && is_trim && !twice_b;
    assign n_ep_live = r_ep_live + 1'b1;
    assign n_ep_seen = r_ep_seen + 1'b1;
    assign node_ext  = {{ENDPOINT_W{1'b0}}, r_node};

    assign o_vld            = r_ctl.vld;
    assign o_res.endpoint   = act ? node_ext[ENDPOINT_W-1:0] : '0;
    assign o_res.was_live   = act;
    assign o_res.seen_twice = act && twice_new;
    assign o_res.live_after = act && !live_we;

    always_ff @(posedge i_clk) begin
        if (r_swp_live) begin
            live_mem[r_swp_cnt] <= {EP_ZERO, 1'b1};
        end else if (i_en && live_we) begin
            live_mem[r_edge] <= {r_ep_live, 1'b0};
        end
        if (i_en) begin
            r_live_q <= live_mem[h_edge];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_swp_seen) begin
            seen_mem[r_swp_cnt] <= {EP_ZERO, 2'b00};
        end else if (i_en && seen_we) begin
            seen_mem[r_node] <= {r_ep_seen, twice_new, 1'b1};
        end
        if (i_en) begin
            r_seen_q <= seen_mem[h_node];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl       <= '0;
            r_kill_live <= 1'b0;
            r_kill_seen <= 1'b0;
            r_fwl_vld   <= 1'b0;
            r_fws_vld   <= 1'b0;
            r_ep_live   <= '0;
            r_ep_seen   <= '0;
            r_swp_live  <= 1'b1;
            r_swp_seen  <= 1'b1;
            r_swp_cnt   <= '0;
        end else if (o_busy) begin
            r_swp_cnt <= r_swp_cnt + 1'b1;
            if (&r_swp_cnt) begin
                r_swp_live <= 1'b0;
                r_swp_seen <= 1'b0;
            end
        end else if (i_en) begin
            r_ctl       <= i_ctl;
            // the next item read its words before this clear or revive took effect
            r_kill_live <= rev;
            r_kill_seen <= clr;
            r_fwl_vld   <= live_we;
            r_fws_vld   <= seen_we;
            if (rev) begin
                r_ep_live <= n_ep_live;
                if (n_ep_live == EP_ZERO) begin
                    r_swp_live <= 1'b1;
                end
            end
            if (clr) begin
                r_ep_seen <= n_ep_seen;
                if (n_ep_seen == EP_ZERO) begin
                    r_swp_seen <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_edge      <= h_edge;
            r_node      <= h_node;
            r_fwl_addr  <= r_edge;
            r_fws_addr  <= r_node;
            r_fws_twice <= twice_new;
        end
    end

endmodule
